/* rtl/mtg_pkg.sv */
// Shared constants, command and status types, and word functions for the
// MT19937 generator. No dependencies; imported by every RTL file but mtg_ram.
`default_nettype none

package mtg_pkg;

	// Size of the state store and the twist offset.
	localparam int STATE_DEPTH   = 624;
	localparam int MIDDLE_OFFSET = 397;
	localparam int MID_OFF       = MIDDLE_OFFSET % STATE_DEPTH;

	// Address of one state word and the index that may also hold the depth itself.
	localparam int ADDR_W = $clog2(STATE_DEPTH);
	localparam int IDX_W  = $clog2(STATE_DEPTH + 1);
	localparam int WORD_W = 32;

	// Seeding recurrence.
	localparam logic [WORD_W-1:0] INIT_MUL   = 32'd1812433253;
	localparam int                INIT_SHIFT = 30;

	// Twist and tempering constants.
	localparam logic [WORD_W-1:0] MT_MATRIX = 32'h9908_B0DF;
	localparam logic [WORD_W-1:0] MT_UPPER  = 32'h8000_0000;
	localparam logic [WORD_W-1:0] MT_LOWER  = 32'h7FFF_FFFF;
	localparam logic [WORD_W-1:0] MT_TB     = 32'h9D2C_5680;
	localparam logic [WORD_W-1:0] MT_TC     = 32'hEFC6_0000;

	// Read address selection for the single read port of the store.
	typedef enum logic [1:0] {
		RD_CUR,
		RD_NXT,
		RD_MID
	} rd_sel_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    load_seed;
		logic    seed_mul;
		logic    seed_wr;
		logic    draw_start;
		logic    cap_cur;
		logic    cap_nxt;
		logic    finish;
		rd_sel_t rd_sel;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic seed_last;
	} sts_t;

	// One step of the twist recurrence for a single word.
	function automatic logic [WORD_W-1:0] twist_word(
		input logic [WORD_W-1:0] cur,
		input logic [WORD_W-1:0] nxt,
		input logic [WORD_W-1:0] mid
	);
		logic [WORD_W-1:0] y;
		logic [WORD_W-1:0] v;
		y = (cur & MT_UPPER) | (nxt & MT_LOWER);
		v = mid ^ (y >> 1);
		if (y[0]) begin
			v = v ^ MT_MATRIX;
		end
		return v;
	endfunction

	// Output tempering.
	function automatic logic [WORD_W-1:0] temper_word(input logic [WORD_W-1:0] x);
		logic [WORD_W-1:0] y;
		y = x ^ (x >> 11);
		y = y ^ ((y << 7) & MT_TB);
		y = y ^ ((y << 15) & MT_TC);
		y = y ^ (y >> 18);
		return y;
	endfunction

endpackage

`default_nettype wire

/* rtl/mtg_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module mtg_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 624
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

/* rtl/mtg_datapath.sv */
// Datapath of the MT19937 generator: state store, seeding multiplier,
// per-word twist, tempering and output word register. Uses mtg_pkg, mtg_ram.
`default_nettype none

module mtg_datapath
	import mtg_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cmd_t              cmd,
	output sts_t                   sts,
	input  wire logic [WORD_W-1:0] seed,
	output logic      [WORD_W-1:0] word
);

	logic [IDX_W-1:0]  widx_q;
	logic [ADDR_W-1:0] k_q;
	logic [ADDR_W-1:0] cur_idx_q;
	logic [WORD_W-1:0] w_q;
	logic [WORD_W-1:0] prod_q;
	logic [WORD_W-1:0] cur_q;
	logic [WORD_W-1:0] nxt_q;
	logic [WORD_W-1:0] word_q;

	logic [ADDR_W-1:0] nxt_idx;
	logic [ADDR_W:0]   mid_sum;
	logic [ADDR_W-1:0] mid_idx;
	logic [WORD_W-1:0] mul_in;
	logic [WORD_W-1:0] seed_word;
	logic [WORD_W-1:0] twisted;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [WORD_W-1:0] ram_wdata;
	logic [ADDR_W-1:0] ram_raddr;
	logic [WORD_W-1:0] ram_rdata;

	// Neighbor and middle indices of the word being drawn, wrapped at the depth.
	assign nxt_idx = (cur_idx_q == ADDR_W'(STATE_DEPTH - 1)) ? '0 : cur_idx_q + 1'b1;
	assign mid_sum = {1'b0, cur_idx_q} + (ADDR_W + 1)'(MID_OFF);
	assign mid_idx = (mid_sum >= (ADDR_W + 1)'(STATE_DEPTH)) ?
		ADDR_W'(mid_sum - (ADDR_W + 1)'(STATE_DEPTH)) : mid_sum[ADDR_W-1:0];

	// Seeding recurrence operands.
	assign mul_in    = w_q ^ (w_q >> INIT_SHIFT);
	assign seed_word = prod_q + {{(WORD_W - ADDR_W){1'b0}}, k_q};

	// The middle word arrives on the read data in the finishing cycle.
	assign twisted = twist_word(cur_q, nxt_q, ram_rdata);

	// Write port selection.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cur_idx_q;
		ram_wdata = twisted;
		if (cmd.load_seed) begin
			ram_we    = 1'b1;
			ram_waddr = '0;
			ram_wdata = seed;
		end else if (cmd.seed_wr) begin
			ram_we    = 1'b1;
			ram_waddr = k_q;
			ram_wdata = seed_word;
		end else if (cmd.finish) begin
			ram_we    = 1'b1;
		end
	end

	// Read port selection.
	always_comb begin
		unique case (cmd.rd_sel)
			RD_CUR:  ram_raddr = cur_idx_q;
			RD_NXT:  ram_raddr = nxt_idx;
			RD_MID:  ram_raddr = mid_idx;
			default: ram_raddr = cur_idx_q;
		endcase
	end

	mtg_ram #(
		.WIDTH(WORD_W),
		.DEPTH(STATE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Word index and seeding counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			widx_q <= IDX_W'(STATE_DEPTH);
			k_q    <= '0;
		end else begin
			if (cmd.load_seed) begin
				widx_q <= IDX_W'(STATE_DEPTH);
				k_q    <= ADDR_W'(1);
			end else if (cmd.seed_wr) begin
				k_q    <= k_q + 1'b1;
			end else if (cmd.finish) begin
				widx_q <= IDX_W'(cur_idx_q) + 1'b1;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (cmd.load_seed) begin
			w_q <= seed;
		end else if (cmd.seed_wr) begin
			w_q <= seed_word;
		end
		if (cmd.seed_mul) begin
			prod_q <= INIT_MUL * mul_in;
		end
		// A spent index starts a new pass of the twist at word zero.
		if (cmd.draw_start) begin
			cur_idx_q <= (widx_q >= IDX_W'(STATE_DEPTH)) ? '0 : widx_q[ADDR_W-1:0];
		end
		if (cmd.cap_cur) begin
			cur_q <= ram_rdata;
		end
		if (cmd.cap_nxt) begin
			nxt_q <= ram_rdata;
		end
		if (cmd.finish) begin
			word_q <= temper_word(twisted);
		end
	end

	assign sts.seed_last = (k_q == ADDR_W'(STATE_DEPTH - 1));
	assign word          = word_q;

endmodule

`default_nettype wire

/* rtl/mtg_ctrl.sv */
// Controller of the MT19937 generator: sequences seeding and draws, and owns
// both channel handshakes. Uses mtg_pkg.
`default_nettype none

module mtg_ctrl
	import mtg_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_stall,
	input  wire logic kind,
	output logic      out_valid,
	input  wire logic out_stall,
	output cmd_t      cmd,
	input  wire sts_t sts
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEED_MUL,
		ST_SEED_WR,
		ST_RD_CUR,
		ST_RD_NXT,
		ST_RD_MID,
		ST_CALC
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	// Command decode and next state.
	always_comb begin
		cmd        = '0;
		cmd.rd_sel = RD_CUR;
		state_d    = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (!kind) begin
						cmd.load_seed = 1'b1;
						state_d       = ST_SEED_MUL;
					end else begin
						cmd.draw_start = 1'b1;
						state_d        = ST_RD_CUR;
					end
				end
			end
			ST_SEED_MUL: begin
				cmd.seed_mul = 1'b1;
				state_d      = ST_SEED_WR;
			end
			ST_SEED_WR: begin
				cmd.seed_wr = 1'b1;
				state_d     = sts.seed_last ? ST_IDLE : ST_SEED_MUL;
			end
			ST_RD_CUR: begin
				cmd.rd_sel = RD_CUR;
				state_d    = ST_RD_NXT;
			end
			ST_RD_NXT: begin
				cmd.rd_sel  = RD_NXT;
				cmd.cap_cur = 1'b1;
				state_d     = ST_RD_MID;
			end
			ST_RD_MID: begin
				cmd.rd_sel  = RD_MID;
				cmd.cap_nxt = 1'b1;
				state_d     = ST_CALC;
			end
			ST_CALC: begin
				// Hold the middle read until the output register is free.
				cmd.rd_sel = RD_MID;
				if (!out_valid_q || !out_stall) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

/* rtl/mersenne_twister_generator.sv */
// Top level of the MT19937 generator: joins the controller and the datapath.
// Uses mtg_pkg, mtg_ctrl, mtg_datapath.
//
// Input channel: in_valid/in_stall with kind and seed. kind low reseeds the
// state from seed and gives no output beat; kind high draws one word.
// Output channel: out_valid/out_stall with the tempered word.
// A draw twists its state word on the fly: it reads the current, next and
// middle words through the single read port of the state RAM, one per cycle,
// writes the twisted word back, tempers it into the output register and holds
// the input until it is done. A reseed writes word zero from seed, then each
// further state word through the seeding multiplier, in a multiply state and
// a write state, and holds the input until the last state word is written.
// The block takes the next input beat while a finished word still waits on the
// output; if a second draw finishes before that word is taken, it waits until
// the receiver lifts out_stall, and the held word does not change. Reset empties
// the output and marks the index as spent, so the first draw after a reseed twists
// word zero. The user issues draws only after a reseed; the block does not enforce it.
`default_nettype none

module mersenne_twister_generator
	import mtg_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic              kind,
	input  wire logic [WORD_W-1:0] seed,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic      [WORD_W-1:0] word
);

	cmd_t cmd;
	sts_t sts;

	mtg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.kind     (kind),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cmd      (cmd),
		.sts      (sts)
	);

	mtg_datapath u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd),
		.sts   (sts),
		.seed  (seed),
		.word  (word)
	);

endmodule

`default_nettype wire

/* rtl/mtg_checker.sv */
// Port-level checks for the MT19937 generator, bound to its top level.
// Uses mtg_pkg and mersenne_twister_generator.
`default_nettype none

module mtg_checker
	import mtg_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_valid,
	input wire logic              in_stall,
	input wire logic              out_valid,
	input wire logic              out_stall,
	input wire logic [WORD_W-1:0] word
);

	// A stalled output beat stays and holds its word.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(word))
		else $error("stalled output beat changed");

	// Every accepted input beat keeps the block busy for at least the next cycle.
	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input accepted again without any work cycle");

	// A new output beat only comes out of a draw that was being worked on.
	a_out_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("output beat appeared while the block was idle");

	// A draw first passes its read states, so an accepted input gives no output next cycle.
	a_no_instant_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !out_valid |=> !out_valid)
		else $error("output beat appeared one cycle after an input beat");

endmodule

bind mersenne_twister_generator mtg_checker u_mtg_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_stall (in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.word     (word)
);

`default_nettype wire
